/* hdl/mbsp_pkg.sv */
// Package for the MIDI byte stream parser.
// Holds status byte codes, event codes, running-status and sysex mode types.
// No dependencies.
package mbsp_pkg;

    localparam int DEFAULT_SYSEX_CAPACITY = 256;

    // status bytes with special handling
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_CLOCK       = 8'hF8;
    localparam logic [7:0] ST_UNDEF_F9    = 8'hF9;
    localparam logic [7:0] ST_START       = 8'hFA;
    localparam logic [7:0] ST_CONTINUE    = 8'hFB;
    localparam logic [7:0] ST_STOP        = 8'hFC;
    localparam logic [7:0] ST_UNDEF_FD    = 8'hFD;
    localparam logic [7:0] ST_ACT_SENSE   = 8'hFE;
    localparam logic [7:0] ST_SYS_RESET   = 8'hFF;

    // high nibble of channel status bytes (bit 7 dropped)
    localparam logic [2:0] HI_NOTE_OFF  = 3'd0;
    localparam logic [2:0] HI_NOTE_ON   = 3'd1;
    localparam logic [2:0] HI_POLY_PRES = 3'd2;
    localparam logic [2:0] HI_CC        = 3'd3;
    localparam logic [2:0] HI_PROGRAM   = 3'd4;
    localparam logic [2:0] HI_CHAN_PRES = 3'd5;
    localparam logic [2:0] HI_BEND      = 3'd6;
    localparam logic [2:0] HI_SYSTEM    = 3'd7;

    typedef enum logic [3:0] {
        EV_NOTE_OFF  = 4'd0,
        EV_NOTE_ON   = 4'd1,
        EV_CC        = 4'd2,
        EV_PROGRAM   = 4'd3,
        EV_AFTERTCH  = 4'd4,
        EV_BEND      = 4'd5,
        EV_CLOCK     = 4'd6,
        EV_START     = 4'd7,
        EV_CONTINUE  = 4'd8,
        EV_STOP      = 4'd9,
        EV_SYSEX_BYT = 4'd10,
        EV_SYSEX_END = 4'd11
    } t_event;

    // running status: event code + 1, zero for none
    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_NOTE_OFF = 3'd1,
        KIND_NOTE_ON  = 3'd2,
        KIND_CC       = 3'd3,
        KIND_PROGRAM  = 3'd4,
        KIND_AFTERTCH = 3'd5,
        KIND_BEND     = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        SX_IDLE = 2'd0,
        SX_RECV = 2'd1,
        SX_OVER = 2'd2
    } t_sx_mode;

endpackage

/* hdl/midi_byte_stream_parser.sv */
// MIDI byte stream parser, top level: running status decode and sysex streaming.
// Depends on mbsp_pkg (codes and types).
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+---------------------------------
//  rx      | in        | i_rx_valid / o_rx_ready       | i_rx_byte
//  evt     | out       | o_evt_valid / i_evt_ready     | o_event_res, o_channel,
//          |           |                               | o_first_data, o_second_data,
//          |           |                               | o_sysex_position, o_sysex_length,
//          |           |                               | o_sysex_overflow
//
// One byte per cycle unless a result stalls. A byte is decoded in the cycle it is accepted
// and its event, if any, sits in the result register from the next cycle on; the decode is
// one level of status compare plus the sysex count compare and increment.
// Synchronous active-low reset clears running status, sysex mode, count and result valid.
// A stalled result only blocks intake when a new byte arrives; the result register is
// refilled in the same cycle the old one is taken.
module midi_byte_stream_parser
    import mbsp_pkg::*;
#(
    parameter int SYSEX_CAPACITY = DEFAULT_SYSEX_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_evt_valid,
    input  logic       i_evt_ready,
    output logic [3:0] o_event_res,
    output logic [4:0] o_channel,
    output logic [6:0] o_first_data,
    output logic [6:0] o_second_data,
    output logic [7:0] o_sysex_position,
    output logic [8:0] o_sysex_length,
    output logic       o_sysex_overflow
);

    // count must hold the capacity itself
    localparam int CW = $clog2(SYSEX_CAPACITY + 1);

    // running status and sysex state
    t_kind          r_kind,     n_kind;
    logic [4:0]     r_chan,     n_chan;
    logic [6:0]     r_held,     n_held;
    logic           r_await,    n_await;
    t_sx_mode       r_sx_mode,  n_sx_mode;
    logic [CW-1:0]  r_sx_count, n_sx_count;

    // result register
    logic           r_out_valid;
    t_event         r_ev,  n_ev;
    logic [4:0]     r_och, n_och;
    logic [6:0]     r_d1,  n_d1;
    logic [6:0]     r_d2,  n_d2;
    logic [7:0]     r_pos, n_pos;
    logic [8:0]     r_len, n_len;
    logic           r_ovf, n_ovf;
    logic           n_emit;

    logic           rx_fire;
    logic [15:0]    count_ext;

    // take a byte whenever the result slot is empty or being drained
    assign o_rx_ready = !r_out_valid || i_evt_ready;
    assign rx_fire    = i_rx_valid && o_rx_ready;
    assign count_ext  = 16'(r_sx_count);

    always_comb begin
        n_kind     = r_kind;
        n_chan     = r_chan;
        n_held     = r_held;
        n_await    = r_await;
        n_sx_mode  = r_sx_mode;
        n_sx_count = r_sx_count;
        n_emit     = 1'b0;
        n_ev       = EV_NOTE_OFF;
        n_och      = '0;
        n_d1       = '0;
        n_d2       = '0;
        n_pos      = '0;
        n_len      = '0;
        n_ovf      = 1'b0;

        if (i_rx_byte[7]) begin
            unique case (i_rx_byte) inside
                ST_CLOCK: begin
                    n_emit = 1'b1;
                    n_ev   = EV_CLOCK;
                end
                ST_START: begin
                    n_emit = 1'b1;
                    n_ev   = EV_START;
                end
                ST_CONTINUE: begin
                    n_emit = 1'b1;
                    n_ev   = EV_CONTINUE;
                end
                ST_STOP: begin
                    n_emit = 1'b1;
                    n_ev   = EV_STOP;
                end
                // undefined and other real-time: sysex untouched
                ST_UNDEF_F9, ST_UNDEF_FD, ST_ACT_SENSE, ST_SYS_RESET: begin
                    n_kind = KIND_NONE;
                end
                ST_SYSEX_START: begin
                    n_kind     = KIND_NONE;
                    n_sx_mode  = SX_RECV;
                    n_sx_count = '0;
                end
                ST_SYSEX_END: begin
                    n_kind = KIND_NONE;
                    if (r_sx_mode != SX_IDLE) begin
                        n_emit     = 1'b1;
                        n_ev       = EV_SYSEX_END;
                        n_len      = count_ext[8:0];
                        n_ovf      = (r_sx_mode == SX_OVER);
                        n_sx_mode  = SX_IDLE;
                        n_sx_count = '0;
                    end
                end
                default: begin
                    // channel status or system common: silently ends any sysex
                    n_sx_mode  = SX_IDLE;
                    n_sx_count = '0;
                    if (i_rx_byte[6:4] == HI_SYSTEM) begin
                        n_kind = KIND_NONE;
                    end else begin
                        n_chan  = {1'b0, i_rx_byte[3:0]} + 5'd1;
                        n_await = 1'b1;
                        unique case (i_rx_byte[6:4])
                            HI_NOTE_OFF:  n_kind = KIND_NOTE_OFF;
                            HI_NOTE_ON:   n_kind = KIND_NOTE_ON;
                            HI_POLY_PRES: n_kind = KIND_NONE;
                            HI_CC:        n_kind = KIND_CC;
                            HI_PROGRAM:   n_kind = KIND_PROGRAM;
                            HI_CHAN_PRES: n_kind = KIND_AFTERTCH;
                            HI_BEND:      n_kind = KIND_BEND;
                            default:      n_kind = KIND_NONE;
                        endcase
                    end
                end
            endcase
        end else begin
            unique case (r_sx_mode)
                SX_RECV: begin
                    if (r_sx_count < CW'(SYSEX_CAPACITY)) begin
                        n_emit     = 1'b1;
                        n_ev       = EV_SYSEX_BYT;
                        n_d1       = i_rx_byte[6:0];
                        n_pos      = count_ext[7:0];
                        n_sx_count = r_sx_count + CW'(1);
                    end else begin
                        n_sx_mode = SX_OVER;
                    end
                end
                SX_OVER: begin
                    // dropped until sysex end
                end
                default: begin
                    unique case (r_kind)
                        KIND_PROGRAM, KIND_AFTERTCH: begin
                            n_emit = 1'b1;
                            n_ev   = t_event'({1'b0, r_kind - 3'd1});
                            n_och  = r_chan;
                            n_d1   = i_rx_byte[6:0];
                        end
                        KIND_NOTE_OFF, KIND_NOTE_ON, KIND_CC, KIND_BEND: begin
                            if (r_await) begin
                                n_held  = i_rx_byte[6:0];
                                n_await = 1'b0;
                            end else begin
                                n_await = 1'b1;
                                n_emit  = 1'b1;
                                n_ev    = t_event'({1'b0, r_kind - 3'd1});
                                n_och   = r_chan;
                                n_d1    = r_held;
                                n_d2    = i_rx_byte[6:0];
                            end
                        end
                        default: begin
                            // no running status: data ignored
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= KIND_NONE;
            r_chan      <= '0;
            r_held      <= '0;
            r_await     <= 1'b1;
            r_sx_mode   <= SX_IDLE;
            r_sx_count  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (rx_fire) begin
                r_kind      <= n_kind;
                r_chan      <= n_chan;
                r_held      <= n_held;
                r_await     <= n_await;
                r_sx_mode   <= n_sx_mode;
                r_sx_count  <= n_sx_count;
                r_out_valid <= n_emit;
            end else if (i_evt_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: loaded only when a new event is produced
    always_ff @(posedge i_clk) begin
        if (rx_fire && n_emit) begin
            r_ev  <= n_ev;
            r_och <= n_och;
            r_d1  <= n_d1;
            r_d2  <= n_d2;
            r_pos <= n_pos;
            r_len <= n_len;
            r_ovf <= n_ovf;
        end
    end

    assign o_evt_valid      = r_out_valid;
    assign o_event_res      = r_ev;
    assign o_channel        = r_och;
    assign o_first_data     = r_d1;
    assign o_second_data    = r_d2;
    assign o_sysex_position = r_pos;
    assign o_sysex_length   = r_len;
    assign o_sysex_overflow = r_ovf;

endmodule
